FILE: hw/rtl/point_affine_transform_core_defines.svh
`ifndef POINT_AFFINE_TRANSFORM_CORE_DEFINES_SVH
`define POINT_AFFINE_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PAT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PAT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pat_pkg.sv
`default_nettype none

package pat_pkg;

	localparam int unsigned DEF_COORD_BITS     = 16;
	localparam int unsigned DEF_TRIG_FRAC_BITS = 15;

	localparam int unsigned SCALE_W    = 8;
	localparam int unsigned ANGLE_W    = 9;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned TAB_IDX_W  = 7;
	localparam int unsigned TAB_LAST   = 90;

	localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
	localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
	localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
	localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

	// pi/180 in Q40
	localparam logic [63:0] DEG_TO_RAD_Q40 = 64'd19190098069;

	typedef enum logic [KIND_W-1:0] {
		KIND_TRANSLATE = 2'd0,
		KIND_SCALE     = 2'd1,
		KIND_ROTATE    = 2'd2
	} kind_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KIND    = 3'd0,
		REG_SHIFT_X = 3'd1,
		REG_SHIFT_Y = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4,
		REG_ANGLE   = 3'd5,
		REG_PIVOT_X = 3'd6,
		REG_PIVOT_Y = 3'd7
	} cfg_reg_e;

	// sine of deg (0..90) via truncated taylor series in q2.30, rounded half up
	// to frac_bits; only ever called with constants to build the lookup table
	function automatic logic [63:0] sin_deg_q(input int unsigned deg,
		input int unsigned frac_bits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        p;
		logic signed [63:0] sum;
		int unsigned        sh;
		int unsigned        n;
		x    = (64'(deg) * DEG_TO_RAD_Q40) >> 10;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (n = 1; n <= 9; n++) begin
			p = (term * x2) >> 30;
			case (n)
				1: term = p / 64'd6;
				2: term = p / 64'd20;
				3: term = p / 64'd42;
				4: term = p / 64'd72;
				5: term = p / 64'd110;
				6: term = p / 64'd156;
				7: term = p / 64'd210;
				8: term = p / 64'd272;
				default: term = p / 64'd342;
			endcase
			if ((n & 1) != 0)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = '0;
		sh = 30 - frac_bits;
		return ($unsigned(sum) + (64'd1 << (sh - 1))) >> sh;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pat_point_if.sv
`default_nettype none

interface pat_point_if #(
	parameter int unsigned COORD_BITS = pat_pkg::DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pat_result_if.sv
`default_nettype none

interface pat_result_if #(
	parameter int unsigned COORD_BITS = pat_pkg::DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic                         clipped;

	modport source (output valid, output out_x, output out_y, output clipped,
		input ready);
	modport sink   (input valid, input out_x, input out_y, input clipped,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pat_trig.sv
`default_nettype none

module pat_trig #(
	parameter int unsigned TRIG_FRAC_BITS = pat_pkg::DEF_TRIG_FRAC_BITS
) (
	input  wire logic        [pat_pkg::ANGLE_W-1:0] angle,
	output logic signed      [TRIG_FRAC_BITS+1:0]   cos_val,
	output logic signed      [TRIG_FRAC_BITS+1:0]   sin_val
);

	localparam int unsigned TW = TRIG_FRAC_BITS + 2;

	typedef enum logic [1:0] {
		QUAD_FIRST,
		QUAD_SECOND,
		QUAD_THIRD,
		QUAD_FOURTH
	} quad_t;

	logic [TRIG_FRAC_BITS:0] sin_tab [0:pat_pkg::TAB_LAST];

	for (genvar g = 0; g <= pat_pkg::TAB_LAST; g++) begin : g_tab
		localparam logic [63:0] TabVal = pat_pkg::sin_deg_q(g, TRIG_FRAC_BITS);
		assign sin_tab[g] = TabVal[TRIG_FRAC_BITS:0];
	end

	logic        [pat_pkg::ANGLE_W-1:0]   ang;
	logic        [pat_pkg::ANGLE_W-1:0]   resid;
	logic        [pat_pkg::TAB_IDX_W-1:0] idx_s;
	logic        [pat_pkg::TAB_IDX_W-1:0] idx_c;
	logic signed [TW-1:0]                 s_val;
	logic signed [TW-1:0]                 c_val;
	quad_t                                quad;

	always_comb begin
		// angles from 360 up wrap once, the field tops out at 511
		ang = (angle >= pat_pkg::DEG_360) ? angle - pat_pkg::DEG_360 : angle;
		if (ang < pat_pkg::DEG_90) begin
			quad  = QUAD_FIRST;
			resid = ang;
		end else if (ang < pat_pkg::DEG_180) begin
			quad  = QUAD_SECOND;
			resid = ang - pat_pkg::DEG_90;
		end else if (ang < pat_pkg::DEG_270) begin
			quad  = QUAD_THIRD;
			resid = ang - pat_pkg::DEG_180;
		end else begin
			quad  = QUAD_FOURTH;
			resid = ang - pat_pkg::DEG_270;
		end
		idx_s = resid[pat_pkg::TAB_IDX_W-1:0];
		idx_c = pat_pkg::TAB_IDX_W'(pat_pkg::TAB_LAST) - idx_s;
		s_val = $signed({1'b0, sin_tab[idx_s]});
		c_val = $signed({1'b0, sin_tab[idx_c]});
		case (quad)
			QUAD_FIRST: begin
				sin_val = s_val;
				cos_val = c_val;
			end
			QUAD_SECOND: begin
				sin_val = c_val;
				cos_val = -s_val;
			end
			QUAD_THIRD: begin
				sin_val = -s_val;
				cos_val = -c_val;
			end
			QUAD_FOURTH: begin
				sin_val = -c_val;
				cos_val = s_val;
			end
			default: begin
				sin_val = s_val;
				cos_val = c_val;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pat_cfg.sv
`default_nettype none

module pat_cfg #(
	parameter int unsigned COORD_BITS     = pat_pkg::DEF_COORD_BITS,
	parameter int unsigned TRIG_FRAC_BITS = pat_pkg::DEF_TRIG_FRAC_BITS,
	parameter int unsigned CFG_W          = (COORD_BITS > pat_pkg::ANGLE_W) ?
		COORD_BITS : pat_pkg::ANGLE_W
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic        [pat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [CFG_W-1:0]              cfg_data,
	output pat_pkg::kind_e                            kind_q,
	output logic signed      [COORD_BITS-1:0]         shift_x_q,
	output logic signed      [COORD_BITS-1:0]         shift_y_q,
	output logic signed      [pat_pkg::SCALE_W-1:0]   scale_x_q,
	output logic signed      [pat_pkg::SCALE_W-1:0]   scale_y_q,
	output logic signed      [COORD_BITS-1:0]         pivot_x_q,
	output logic signed      [COORD_BITS-1:0]         pivot_y_q,
	output logic signed      [TRIG_FRAC_BITS+1:0]     cos_q,
	output logic signed      [TRIG_FRAC_BITS+1:0]     sin_q
);

	localparam int unsigned TW = TRIG_FRAC_BITS + 2;
	localparam logic signed [TW-1:0] TRIG_ONE = {2'b01, {TRIG_FRAC_BITS{1'b0}}};

	logic signed [TW-1:0] new_cos;
	logic signed [TW-1:0] new_sin;

	// trig terms come straight from the written angle, no angle register kept
	pat_trig #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_trig (
		.angle   (cfg_data[pat_pkg::ANGLE_W-1:0]),
		.cos_val (new_cos),
		.sin_val (new_sin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= pat_pkg::KIND_TRANSLATE;
			shift_x_q <= '0;
			shift_y_q <= '0;
			scale_x_q <= pat_pkg::SCALE_W'(1);
			scale_y_q <= pat_pkg::SCALE_W'(1);
			pivot_x_q <= '0;
			pivot_y_q <= '0;
			cos_q     <= TRIG_ONE;
			sin_q     <= '0;
		end else if (cfg_we) begin
			case (pat_pkg::cfg_reg_e'(cfg_index))
				pat_pkg::REG_KIND:    kind_q <= pat_pkg::kind_e'(cfg_data[pat_pkg::KIND_W-1:0]);
				pat_pkg::REG_SHIFT_X: shift_x_q <= cfg_data[COORD_BITS-1:0];
				pat_pkg::REG_SHIFT_Y: shift_y_q <= cfg_data[COORD_BITS-1:0];
				pat_pkg::REG_SCALE_X: scale_x_q <= cfg_data[pat_pkg::SCALE_W-1:0];
				pat_pkg::REG_SCALE_Y: scale_y_q <= cfg_data[pat_pkg::SCALE_W-1:0];
				pat_pkg::REG_ANGLE: begin
					cos_q <= new_cos;
					sin_q <= new_sin;
				end
				pat_pkg::REG_PIVOT_X: pivot_x_q <= cfg_data[COORD_BITS-1:0];
				pat_pkg::REG_PIVOT_Y: pivot_y_q <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pat_datapath.sv
`default_nettype none

module pat_datapath #(
	parameter int unsigned COORD_BITS     = pat_pkg::DEF_COORD_BITS,
	parameter int unsigned TRIG_FRAC_BITS = pat_pkg::DEF_TRIG_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pat_pkg::kind_e                      kind,
	input  wire logic signed [COORD_BITS-1:0]        shift_x,
	input  wire logic signed [COORD_BITS-1:0]        shift_y,
	input  wire logic signed [pat_pkg::SCALE_W-1:0]  scale_x,
	input  wire logic signed [pat_pkg::SCALE_W-1:0]  scale_y,
	input  wire logic signed [COORD_BITS-1:0]        pivot_x,
	input  wire logic signed [COORD_BITS-1:0]        pivot_y,
	input  wire logic signed [TRIG_FRAC_BITS+1:0]    cos_term,
	input  wire logic signed [TRIG_FRAC_BITS+1:0]    sin_term,
	pat_point_if.sink                                point,
	pat_result_if.source                             result
);

	localparam int unsigned F  = TRIG_FRAC_BITS;
	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = COORD_BITS + F + 3;
	localparam int unsigned SW = COORD_BITS + F + 4;
	localparam int unsigned MW = COORD_BITS + pat_pkg::SCALE_W;
	localparam int unsigned RW = COORD_BITS + pat_pkg::SCALE_W + 1;

	// input register
	logic                         v_s1;
	logic signed [COORD_BITS-1:0] px_s1;
	logic signed [COORD_BITS-1:0] py_s1;

	// result register
	logic                         res_v_q;
	logic signed [COORD_BITS-1:0] out_x_q;
	logic signed [COORD_BITS-1:0] out_y_q;
	logic                         clipped_q;

	logic advance;

	assign advance      = !res_v_q || result.ready;
	assign point.ready  = !v_s1 || advance;

	// rotate about pivot
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [PW-1:0] m_xc;
	logic signed [PW-1:0] m_ys;
	logic signed [PW-1:0] m_xs;
	logic signed [PW-1:0] m_yc;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] bias_x;
	logic signed [SW-1:0] bias_y;
	logic signed [RW-1:0] rot_x;
	logic signed [RW-1:0] rot_y;

	assign dx   = DW'(px_s1) - DW'(pivot_x);
	assign dy   = DW'(py_s1) - DW'(pivot_y);
	assign m_xc = PW'(dx) * PW'(cos_term);
	assign m_ys = PW'(dy) * PW'(sin_term);
	assign m_xs = PW'(dx) * PW'(sin_term);
	assign m_yc = PW'(dy) * PW'(cos_term);

	assign sum_x = (SW'(pivot_x) <<< F) + SW'(m_xc) - SW'(m_ys);
	assign sum_y = (SW'(pivot_y) <<< F) + SW'(m_xs) + SW'(m_yc);

	// add all-ones fraction on negatives so the shift rounds toward zero
	assign bias_x = sum_x + $signed({{(SW - F){1'b0}}, {F{sum_x[SW-1]}}});
	assign bias_y = sum_y + $signed({{(SW - F){1'b0}}, {F{sum_y[SW-1]}}});
	assign rot_x  = RW'($signed(bias_x[SW-1:F]));
	assign rot_y  = RW'($signed(bias_y[SW-1:F]));

	// scale
	logic signed [MW-1:0] prod_x;
	logic signed [MW-1:0] prod_y;

	assign prod_x = MW'(px_s1) * MW'(scale_x);
	assign prod_y = MW'(py_s1) * MW'(scale_y);

	logic signed [RW-1:0] res_x;
	logic signed [RW-1:0] res_y;
	logic                 ov_x;
	logic                 ov_y;

	always_comb begin
		case (kind)
			pat_pkg::KIND_TRANSLATE: begin
				res_x = RW'(px_s1) + RW'(shift_x);
				res_y = RW'(py_s1) + RW'(shift_y);
			end
			pat_pkg::KIND_SCALE: begin
				res_x = RW'(prod_x);
				res_y = RW'(prod_y);
			end
			pat_pkg::KIND_ROTATE: begin
				res_x = rot_x;
				res_y = rot_y;
			end
			default: begin
				res_x = RW'(px_s1);
				res_y = RW'(py_s1);
			end
		endcase
		// out of range when the result sign bit and the bits above it disagree
		ov_x = !((&res_x[RW-1:COORD_BITS-1]) || !(|res_x[RW-1:COORD_BITS-1]));
		ov_y = !((&res_y[RW-1:COORD_BITS-1]) || !(|res_y[RW-1:COORD_BITS-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (point.valid && point.ready)
				v_s1 <= 1'b1;
			else if (advance)
				v_s1 <= 1'b0;
			if (advance)
				res_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (point.valid && point.ready) begin
			px_s1 <= point.point_x;
			py_s1 <= point.point_y;
		end
		if (advance && v_s1) begin
			out_x_q   <= ov_x ? {res_x[RW-1], {(COORD_BITS - 1){~res_x[RW-1]}}} :
				res_x[COORD_BITS-1:0];
			out_y_q   <= ov_y ? {res_y[RW-1], {(COORD_BITS - 1){~res_y[RW-1]}}} :
				res_y[COORD_BITS-1:0];
			clipped_q <= ov_x || ov_y;
		end
	end

	assign result.valid   = res_v_q;
	assign result.out_x   = out_x_q;
	assign result.out_y   = out_y_q;
	assign result.clipped = clipped_q;

endmodule

`default_nettype wire

FILE: hw/rtl/point_affine_transform_core.sv
// an accepted request is held in the input register, then in the result register
// throughput: one request per cycle while result.ready is high, set by the single
// pass from the input register through the multipliers and saturation into the
// result register; reset: pipeline emptied, transform translate with zero shift,
// scales 1, pivot 0, cosine term 1.0 and sine term 0
`default_nettype none

`include "point_affine_transform_core_defines.svh"

module point_affine_transform_core #(
	parameter int unsigned COORD_BITS     = pat_pkg::DEF_COORD_BITS,
	parameter int unsigned TRIG_FRAC_BITS = pat_pkg::DEF_TRIG_FRAC_BITS,
	parameter int unsigned CFG_W          = (COORD_BITS > pat_pkg::ANGLE_W) ?
		COORD_BITS : pat_pkg::ANGLE_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	pat_point_if.sink                          point,
	pat_result_if.source                       result
);

	localparam int unsigned TW = TRIG_FRAC_BITS + 2;
	localparam logic signed [TW-1:0] TRIG_ONE = {2'b01, {TRIG_FRAC_BITS{1'b0}}};
	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

	pat_pkg::kind_e                       kind;
	logic signed [COORD_BITS-1:0]         shift_x;
	logic signed [COORD_BITS-1:0]         shift_y;
	logic signed [pat_pkg::SCALE_W-1:0]   scale_x;
	logic signed [pat_pkg::SCALE_W-1:0]   scale_y;
	logic signed [COORD_BITS-1:0]         pivot_x;
	logic signed [COORD_BITS-1:0]         pivot_y;
	logic signed [TW-1:0]                 cos_term;
	logic signed [TW-1:0]                 sin_term;

	pat_cfg #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.CFG_W          (CFG_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kind_q    (kind),
		.shift_x_q (shift_x),
		.shift_y_q (shift_y),
		.scale_x_q (scale_x),
		.scale_y_q (scale_y),
		.pivot_x_q (pivot_x),
		.pivot_y_q (pivot_y),
		.cos_q     (cos_term),
		.sin_q     (sin_term)
	);

	pat_datapath #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.kind     (kind),
		.shift_x  (shift_x),
		.shift_y  (shift_y),
		.scale_x  (scale_x),
		.scale_y  (scale_y),
		.pivot_x  (pivot_x),
		.pivot_y  (pivot_y),
		.cos_term (cos_term),
		.sin_term (sin_term),
		.point    (point),
		.result   (result)
	);

	// a clipped result carries a rail value on at least one axis
	`PAT_ASSERT_NOW(a_clip_at_rail, result.valid && result.clipped, result.out_x == COORD_MAX || result.out_x == COORD_MIN || result.out_y == COORD_MAX || result.out_y == COORD_MIN, "clipped without a saturated coordinate")

	// pass-through for an unused transform code never saturates
	`PAT_ASSERT_NOW(a_pass_no_clip, result.valid && kind != pat_pkg::KIND_TRANSLATE && kind != pat_pkg::KIND_SCALE && kind != pat_pkg::KIND_ROTATE, !result.clipped, "pass-through request reported clipped")

	// a zero angle loads cosine 1.0 and sine 0
	`PAT_ASSERT_NEXT(a_zero_angle, cfg_we && cfg_index == pat_pkg::REG_ANGLE && cfg_data[pat_pkg::ANGLE_W-1:0] == '0, cos_term == TRIG_ONE && sin_term == '0, "zero angle gave wrong trig terms")

endmodule

`default_nettype wire
